// File: rtl/hvd_pkg.sv
// Package with shared types, constants and arithmetic for the HMM Viterbi decoder.
`default_nettype none
package hvd_pkg;

  localparam int NUM_STATES  = 16;
  localparam int IN_DEGREE   = 16;
  localparam int NUM_FRAMES  = 64;
  localparam int STATE_W     = 4;
  localparam int SLOT_W      = 4;
  localparam int TIME_W      = 6;
  localparam int FRAME_CNT_W = 7;
  localparam int SCORE_W     = 32;
  localparam int CFG_W       = 5;
  localparam int SLOT_ADDR_W = STATE_W + SLOT_W;
  localparam int BP_ADDR_W   = TIME_W + STATE_W;

  localparam logic [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
  localparam logic [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic [CFG_W-1:0]   NUM_STATES_RESET = CFG_W'(NUM_STATES);

  typedef enum logic [1:0] {
    CMD_LOAD_SLOT = 2'd0,
    CMD_LOAD_INIT = 2'd1,
    CMD_EMISSION  = 2'd2,
    CMD_FINISH    = 2'd3
  } cmd_e_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EM_SCAN,
    ST_EM_WRITE,
    ST_FIN_SCAN,
    ST_TB_EMIT,
    ST_TB_WAIT
  } ctrl_state_t;

  typedef struct packed {
    logic load_slot;
    logic load_init;
    logic start_em;
    logic drop;
    logic scan_step;
    logic em_write;
    logic fin_start;
    logic fin_step;
    logic tb_emit;
    logic tb_adv;
    logic clear_run;
  } ctrl_cmd_t;

  typedef struct packed {
    logic state_in_range;
    logic frame_full;
    logic frame_zero;
    logic scan_done;
    logic fin_done;
    logic out_free;
    logic tb_last;
  } dp_status_t;

  // Signed add clamped to the 32-bit range.
  function automatic logic [SCORE_W-1:0] sat_add(input logic [SCORE_W-1:0] a,
                                                 input logic [SCORE_W-1:0] b);
    logic [SCORE_W:0] s;
    s = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
    if (s[SCORE_W] != s[SCORE_W-1]) begin
      return s[SCORE_W] ? SCORE_MIN : SCORE_MAX;
    end
    return s[SCORE_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/hvd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hvd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/hvd_ctrl.sv
// Controller state machine sequencing loads, emission scans, finish search and traceback.
`default_nettype none
module hvd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         command,
  input  wire hvd_pkg::dp_status_t status,
  output hvd_pkg::ctrl_cmd_t      cmd
);
  import hvd_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (cmd_e_t'(command))
            CMD_LOAD_SLOT: cmd.load_slot = 1'b1;
            CMD_LOAD_INIT: cmd.load_init = 1'b1;
            CMD_EMISSION: begin
              if (status.state_in_range) begin
                if (status.frame_full) begin
                  cmd.drop = 1'b1;
                end else begin
                  cmd.start_em = 1'b1;
                  // The first frame takes its metric from the initial scores.
                  state_next = status.frame_zero ? ST_EM_WRITE : ST_EM_SCAN;
                end
              end
            end
            CMD_FINISH: begin
              cmd.fin_start = 1'b1;
              state_next    = ST_FIN_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_EM_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_EM_WRITE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_EM_WRITE: begin
        cmd.em_write = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_FIN_SCAN: begin
        if (status.fin_done) begin
          state_next = ST_TB_EMIT;
        end else begin
          cmd.fin_step = 1'b1;
        end
      end
      ST_TB_EMIT: begin
        if (status.out_free) begin
          cmd.tb_emit = 1'b1;
          if (status.tb_last) begin
            cmd.clear_run = 1'b1;
            state_next    = ST_IDLE;
          end else begin
            state_next = ST_TB_WAIT;
          end
        end
      end
      ST_TB_WAIT: begin
        cmd.tb_adv = 1'b1;
        state_next = ST_TB_EMIT;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/hvd_datapath.sv
// Datapath: slot and back-pointer memories, metrics, add-compare unit and output register.
`default_nettype none
module hvd_datapath (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire hvd_pkg::ctrl_cmd_t    cmd,
  output hvd_pkg::dp_status_t        status,
  input  wire logic                  cfg_valid,
  input  wire logic [4:0]            cfg_data,
  input  wire logic [3:0]            state_index,
  input  wire logic [3:0]            slot_index,
  input  wire logic [3:0]            source_state,
  input  wire logic signed [31:0]    score,
  input  wire logic                  score_valid,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [5:0]                 time_index,
  output logic [3:0]                 best_state,
  output logic                       state_valid,
  output logic signed [31:0]         path_score,
  output logic                       path_valid,
  output logic                       overflow,
  output logic                       last
);
  import hvd_pkg::*;

  logic [CFG_W-1:0]       num_states;
  logic [CFG_W-1:0]       n_eff;
  logic [NUM_STATES-1:0]  slot_valid [IN_DEGREE];
  logic [SCORE_W-1:0]     init_score [NUM_STATES];
  logic [NUM_STATES-1:0]  init_valid;
  logic [SCORE_W-1:0]     path_val [NUM_STATES];
  logic [NUM_STATES-1:0]  path_ok;
  logic [SCORE_W-1:0]     next_val [NUM_STATES];
  logic [NUM_STATES-1:0]  next_ok;
  logic [FRAME_CNT_W-1:0] frame_count;
  logic                   dropped;

  logic [STATE_W-1:0]     em_state;
  logic [SCORE_W-1:0]     em_score;
  logic                   em_ok;
  logic [SLOT_W:0]        scan_cnt;
  logic                   rd_vld;
  logic [SLOT_ADDR_W-1:0] rd_addr_q;
  logic                   best_ok;
  logic signed [SCORE_W-1:0] best_val;
  logic [STATE_W-1:0]     best_ptr;
  logic [STATE_W:0]       fin_idx;
  logic [STATE_W-1:0]     cur;
  logic [TIME_W-1:0]      tb_time;

  logic [STATE_W+SCORE_W-1:0] slot_rdata;
  logic [STATE_W-1:0]     bp_rdata;
  logic [STATE_W-1:0]     src;
  logic [SCORE_W-1:0]     weight;
  logic [STATE_W-1:0]     pm_addr;
  logic                   pm_ok;
  logic signed [SCORE_W-1:0] pm_val;
  logic signed [SCORE_W-1:0] cand_val;
  logic                   cand;
  logic                   fin_cand;
  logic                   new_ok;
  logic [SCORE_W-1:0]     new_val;
  logic                   close_frame;

  // Effective state count is clamped to one through the maximum.
  always_comb begin
    if (num_states == '0) begin
      n_eff = CFG_W'(1);
    end else if (num_states > CFG_W'(NUM_STATES)) begin
      n_eff = CFG_W'(NUM_STATES);
    end else begin
      n_eff = num_states;
    end
  end

  hvd_ram #(
    .WIDTH(STATE_W + SCORE_W),
    .DEPTH(NUM_STATES * IN_DEGREE)
  ) u_slot_ram (
    .clk   (clk),
    .we    (cmd.load_slot),
    .waddr ({state_index, slot_index}),
    .wdata ({source_state, score}),
    .raddr ({em_state, scan_cnt[SLOT_W-1:0]}),
    .rdata (slot_rdata)
  );

  hvd_ram #(
    .WIDTH(STATE_W),
    .DEPTH(NUM_FRAMES * NUM_STATES)
  ) u_bp_ram (
    .clk   (clk),
    .we    (cmd.em_write && (frame_count != '0)),
    .waddr ({frame_count[TIME_W-1:0], em_state}),
    .wdata (best_ptr),
    .raddr ({tb_time, cur}),
    .rdata (bp_rdata)
  );

  assign src    = slot_rdata[SCORE_W +: STATE_W];
  assign weight = slot_rdata[SCORE_W-1:0];

  // One read port on the path metrics, shared by the slot scan and the finish search.
  assign pm_addr  = cmd.fin_step ? fin_idx[STATE_W-1:0] : src;
  assign pm_ok    = path_ok[pm_addr];
  assign pm_val   = path_val[pm_addr];
  assign cand_val = sat_add(pm_val, weight);

  assign cand = rd_vld && slot_valid[rd_addr_q[SLOT_W +: STATE_W]][rd_addr_q[SLOT_W-1:0]] &&
                ({1'b0, src} < n_eff) && pm_ok && (!best_ok || (cand_val > best_val));

  assign fin_cand = cmd.fin_step && !fin_idx[STATE_W] && (fin_idx < n_eff) &&
                    (frame_count != '0) && pm_ok && (!best_ok || (pm_val > best_val));

  always_comb begin
    if (frame_count == '0) begin
      new_ok  = init_valid[em_state] && em_ok;
      new_val = sat_add(init_score[em_state], em_score);
    end else begin
      new_ok  = best_ok && em_ok;
      new_val = sat_add(best_val, em_score);
    end
  end

  assign close_frame = ({1'b0, em_state} == (n_eff - CFG_W'(1)));

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_states  <= NUM_STATES_RESET;
      init_valid  <= '0;
      path_ok     <= '0;
      next_ok     <= '0;
      frame_count <= '0;
      dropped     <= 1'b0;
      rd_vld      <= 1'b0;
      out_valid   <= 1'b0;
      for (int i = 0; i < IN_DEGREE; i++) begin
        slot_valid[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        num_states <= cfg_data;
      end
      if (cmd.load_slot) begin
        slot_valid[state_index][slot_index] <= score_valid;
      end
      if (cmd.load_init) begin
        init_valid[state_index] <= score_valid;
      end
      if (cmd.drop) begin
        dropped <= 1'b1;
      end
      rd_vld <= cmd.scan_step && !scan_cnt[SLOT_W];
      if (cmd.em_write) begin
        if (close_frame) begin
          for (int i = 0; i < NUM_STATES; i++) begin
            path_ok[i] <= (STATE_W'(i) == em_state) ? new_ok : next_ok[i];
          end
          next_ok     <= '0;
          frame_count <= frame_count + FRAME_CNT_W'(1);
        end else begin
          next_ok[em_state] <= new_ok;
        end
      end
      if (cmd.tb_emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.clear_run) begin
        path_ok     <= '0;
        next_ok     <= '0;
        frame_count <= '0;
        dropped     <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_init) begin
      init_score[state_index] <= score;
    end
    if (cmd.start_em) begin
      em_state <= state_index;
      em_score <= score;
      em_ok    <= score_valid;
      scan_cnt <= '0;
      best_ok  <= 1'b0;
      best_val <= '0;
      best_ptr <= '0;
    end
    if (cmd.scan_step) begin
      rd_addr_q <= {em_state, scan_cnt[SLOT_W-1:0]};
      scan_cnt  <= scan_cnt + (SLOT_W+1)'(1);
      if (cand) begin
        best_ok  <= 1'b1;
        best_val <= cand_val;
        best_ptr <= src;
      end
    end
    if (cmd.em_write) begin
      if (close_frame) begin
        for (int i = 0; i < NUM_STATES; i++) begin
          path_val[i] <= (STATE_W'(i) == em_state) ? new_val : next_val[i];
        end
      end else begin
        next_val[em_state] <= new_val;
      end
    end
    // The finish search reuses the best-metric registers for the final maximum.
    if (cmd.fin_start) begin
      fin_idx  <= '0;
      best_ok  <= 1'b0;
      best_val <= '0;
      cur      <= '0;
      tb_time  <= (frame_count == '0) ? '0 : TIME_W'(frame_count - FRAME_CNT_W'(1));
    end
    if (cmd.fin_step) begin
      if (!fin_idx[STATE_W]) begin
        fin_idx <= fin_idx + (STATE_W+1)'(1);
      end
      if (fin_cand) begin
        best_ok  <= 1'b1;
        best_val <= pm_val;
        cur      <= fin_idx[STATE_W-1:0];
      end
    end
    if (cmd.tb_emit) begin
      time_index  <= tb_time;
      best_state  <= best_ok ? cur : '0;
      state_valid <= best_ok;
      path_score  <= best_ok ? best_val : SCORE_MIN;
      path_valid  <= best_ok;
      overflow    <= dropped;
      last        <= (tb_time == '0);
    end
    if (cmd.tb_adv) begin
      if (best_ok) begin
        cur <= bp_rdata;
      end
      tb_time <= tb_time - TIME_W'(1);
    end
  end

  always_comb begin
    status.state_in_range = ({1'b0, state_index} < n_eff);
    status.frame_full     = frame_count[FRAME_CNT_W-1];
    status.frame_zero     = (frame_count == '0);
    status.scan_done      = (scan_cnt == (SLOT_W+1)'(IN_DEGREE + 1));
    status.fin_done       = fin_idx[STATE_W];
    status.out_free       = !out_valid || !out_stall;
    status.tb_last        = (tb_time == '0);
  end

endmodule
`default_nettype wire

// File: rtl/hmm_viterbi_decoder_unit.sv
// Top level of the log-domain HMM Viterbi decoder.
// Input words carry a command: load a transition slot, load an initial score,
// deliver one state's emission score, or finish the run. A word is taken when
// in_valid is high and in_stall is low; in_stall is high while a word is being
// worked on. The first frame takes its metric from the initial scores; for
// later frames the add-compare unit reads one incoming slot per cycle from the
// slot memory. Finish searches the final metrics and then walks the back
// pointer memory, one path word at a time from the last frame to frame 0; the
// word for frame 0 carries last. A stalled output word holds and the traceback
// waits for it. The num_states register is written on the cfg channel (always
// ready); the user must write it only while the block is idle, and the block
// itself does not enforce this. Reset (rst, synchronous) clears the slot and
// initial valid bits, the metric valid bits, frame count and overflow flag,
// and sets num_states to 16; no clearing pass is needed.
`default_nettype none
module hmm_viterbi_decoder_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [4:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         command,
  input  wire logic [3:0]         state_index,
  input  wire logic [3:0]         slot_index,
  input  wire logic [3:0]         source_state,
  input  wire logic signed [31:0] score,
  input  wire logic               score_valid,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [5:0]              time_index,
  output logic [3:0]              best_state,
  output logic                    state_valid,
  output logic signed [31:0]      path_score,
  output logic                    path_valid,
  output logic                    overflow,
  output logic                    last
);
  import hvd_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  hvd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .command  (command),
    .status   (status),
    .cmd      (cmd)
  );

  hvd_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .state_index  (state_index),
    .slot_index   (slot_index),
    .source_state (source_state),
    .score        (score),
    .score_valid  (score_valid),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .time_index   (time_index),
    .best_state   (best_state),
    .state_valid  (state_valid),
    .path_score   (path_score),
    .path_valid   (path_valid),
    .overflow     (overflow),
    .last         (last)
  );

endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the HMM Viterbi decoder with its own path predictor.
`timescale 1ns / 1ps
module testbench;
  import hvd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 40;

  typedef struct {
    cmd_e_t            cmd;
    logic [3:0]        st;
    logic [3:0]        sl;
    logic [3:0]        src;
    logic signed [31:0] sc;
    logic              ok;
  } word_t;

  typedef struct packed {
    logic [5:0]  time_index;
    logic [3:0]  best_state;
    logic        state_valid;
    logic [31:0] path_score;
    logic        path_valid;
    logic        overflow;
    logic        last;
  } path_word_t;

  typedef struct {
    logic              ok;
    logic signed [31:0] val;
  } metric_t;

  typedef struct {
    word_t      w;
    logic       typed;
    path_word_t exp_word;
  } row_t;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [4:0] cfg_data;
  logic in_valid, in_stall;
  logic [1:0] command;
  logic [3:0] state_index, slot_index, source_state;
  logic signed [31:0] score;
  logic score_valid;
  logic out_valid, out_stall;
  logic [5:0] time_index;
  logic [3:0] best_state;
  logic state_valid, path_valid, overflow, last;
  logic signed [31:0] path_score;

  hmm_viterbi_decoder_unit u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .command(command),
    .state_index(state_index), .slot_index(slot_index),
    .source_state(source_state), .score(score), .score_valid(score_valid),
    .out_valid(out_valid), .out_stall(out_stall), .time_index(time_index),
    .best_state(best_state), .state_valid(state_valid),
    .path_score(path_score), .path_valid(path_valid),
    .overflow(overflow), .last(last)
  );

  // Predictor state.
  logic [4:0]         m_num_states;
  logic [3:0]         m_src [256];
  logic signed [31:0] m_weight [256];
  logic               m_slot_ok [256];
  logic signed [31:0] m_init [16];
  logic               m_init_ok [16];
  metric_t            m_cur [16];
  metric_t            m_nxt [16];
  logic [4:0]         m_bp [1024];
  int                 m_frames;
  logic               m_dropped;

  path_word_t decoded_q[$];
  int mismatches, words_sent, words_checked, runs_done;
  int quiet_cycles;
  bit hold_req, tx_fast, rx_fast;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic signed [31:0] clamp_add(logic signed [31:0] a,
                                                   logic signed [31:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  function automatic int active_states();
    if (m_num_states == 0) return 1;
    if (m_num_states > 16) return 16;
    return m_num_states;
  endfunction

  function automatic void clear_decode();
    for (int i = 0; i < 16; i++) begin
      m_cur[i] = '{1'b0, 0};
      m_nxt[i] = '{1'b0, 0};
    end
    m_frames = 0;
    m_dropped = 1'b0;
  endfunction

  function automatic void add_emission(int j, logic signed [31:0] e, logic e_ok, int n);
    metric_t best;
    logic [4:0] ptr;
    int k;
    logic signed [31:0] v;
    best = '{1'b0, 0};
    ptr = '0;
    if (m_frames == 0) begin
      if (m_init_ok[j] && e_ok) best = '{1'b1, clamp_add(m_init[j], e)};
      m_nxt[j] = best;
    end else begin
      for (int s = 0; s < 16; s++) begin
        k = j * 16 + s;
        if (!m_slot_ok[k] || m_src[k] >= n || !m_cur[m_src[k]].ok) continue;
        v = clamp_add(m_cur[m_src[k]].val, m_weight[k]);
        if (!best.ok || v > best.val) begin
          best = '{1'b1, v};
          ptr = {1'b1, m_src[k]};
        end
      end
      m_bp[m_frames * 16 + j] = ptr;
      if (best.ok && e_ok) m_nxt[j].val = clamp_add(best.val, e);
      m_nxt[j].ok = best.ok && e_ok;
    end
    if (j == n - 1) begin
      m_cur = m_nxt;
      for (int i = 0; i < 16; i++) m_nxt[i] = '{1'b0, 0};
      m_frames++;
    end
  endfunction

  function automatic void predict_path(ref path_word_t res[$]);
    int n, cur, cnt;
    logic found;
    logic signed [31:0] best;
    path_word_t pw;
    n = active_states();
    found = 1'b0;
    best = 0;
    cur = 0;
    for (int j = 0; j < n; j++)
      if (m_frames > 0 && m_cur[j].ok && (!found || m_cur[j].val > best)) begin
        found = 1'b1;
        best = m_cur[j].val;
        cur = j;
      end
    cnt = (m_frames == 0) ? 1 : m_frames;
    for (int t = cnt - 1; t >= 0; t--) begin
      pw.time_index = t[5:0];
      pw.best_state = found ? cur[3:0] : 4'd0;
      pw.state_valid = found;
      pw.path_score = found ? best : SCORE_MIN;
      pw.path_valid = found;
      pw.overflow = m_dropped;
      pw.last = (t == 0);
      res.push_back(pw);
      if (found && t > 0) cur = m_bp[t * 16 + cur][3:0];
    end
    clear_decode();
  endfunction

  function automatic void step_model(word_t w, ref path_word_t res[$]);
    int n;
    n = active_states();
    case (w.cmd)
      CMD_LOAD_SLOT: begin
        m_src[{w.st, w.sl}] = w.src;
        m_weight[{w.st, w.sl}] = w.sc;
        m_slot_ok[{w.st, w.sl}] = w.ok;
      end
      CMD_LOAD_INIT: begin
        m_init[w.st] = w.sc;
        m_init_ok[w.st] = w.ok;
      end
      CMD_EMISSION: begin
        if (w.st < n) begin
          if (m_frames >= NUM_FRAMES) m_dropped = 1'b1;
          else add_emission(w.st, w.sc, w.ok, n);
        end
      end
      default: predict_path(res);
    endcase
  endfunction

  // Drives one word from the falling edge and returns at the falling edge after it is taken.
  task automatic send(word_t w, bit typed = 1'b0, path_word_t tw = '0);
    int gap;
    path_word_t res[$];
    gap = tx_fast ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= w.cmd;
    state_index <= w.st;
    slot_index <= w.sl;
    source_state <= w.src;
    score <= w.sc;
    score_valid <= w.ok;
    do @(posedge clk); while (in_stall);
    step_model(w, res);
    if (typed) decoded_q.push_back(tw);
    else foreach (res[i]) decoded_q.push_back(res[i]);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    wait (decoded_q.size() == 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_states(logic [4:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    m_num_states = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] pick_score();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return $urandom_range(0, 65536 * 4);
      default: return -$signed($urandom_range(0, 65536 * 20));
    endcase
  endfunction

  function automatic word_t mk(cmd_e_t c, int st, int sl, int src,
                               logic signed [31:0] sc, logic ok);
    word_t w;
    w.cmd = c;
    w.st = st[3:0];
    w.sl = sl[3:0];
    w.src = src[3:0];
    w.sc = sc;
    w.ok = ok;
    return w;
  endfunction

  // A run: fresh transitions and initial scores, a few frames, then finish.
  task automatic decode_run(int frames, bit noisy);
    int n;
    n = active_states();
    for (int j = 0; j < n; j++) begin
      send(mk(CMD_LOAD_INIT, j, 0, 0, pick_score(), $urandom_range(0, 5) != 0));
      for (int s = 0; s < $urandom_range(1, 3); s++)
        send(mk(CMD_LOAD_SLOT, j, $urandom_range(0, 15),
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, n - 1),
                pick_score(), $urandom_range(0, 7) != 0));
    end
    for (int f = 0; f < frames; f++)
      for (int j = 0; j < n; j++) begin
        if (noisy && $urandom_range(0, 19) == 0) continue;
        if (noisy && $urandom_range(0, 19) == 0)
          send(mk(CMD_EMISSION, j, $urandom, $urandom, pick_score(), $urandom));
        if (noisy && n < 16 && $urandom_range(0, 19) == 0)
          send(mk(CMD_EMISSION, $urandom_range(n, 15), 0, 0, pick_score(), 1'b1));
        send(mk(CMD_EMISSION, j, $urandom, $urandom, pick_score(),
                $urandom_range(0, 9) != 0));
      end
    if (noisy && n > 1 && $urandom_range(0, 3) == 0)
      send(mk(CMD_EMISSION, 0, 0, 0, pick_score(), 1'b1));
    send(mk(CMD_FINISH, $urandom, $urandom, $urandom, $urandom, $urandom));
    runs_done++;
  endtask

  // Results are checked against the oldest expectation as they are taken.
  always @(posedge clk) begin
    path_word_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{time_index, best_state, state_valid, path_score, path_valid, overflow, last};
      if (decoded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected path word %p", got);
      end else begin
        want = decoded_q.pop_front();
        words_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("path word mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Receiver: a random hold before each word, and one long hold on request.
  initial begin
    int w;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        w = rx_fast ? 0 : $urandom_range(0, 15);
        if (w > 0) begin
          out_stall <= 1'b1;
          repeat (w) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
      do @(posedge clk); while (!out_valid && !hold_req);
      @(negedge clk);
    end
  end

  initial begin
    row_t rows[$];
    path_word_t none_word;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    command = CMD_LOAD_SLOT;
    state_index = '0;
    slot_index = '0;
    source_state = '0;
    score = '0;
    score_valid = 1'b0;
    hold_req = 1'b0;
    tx_fast = 1'b0;
    rx_fast = 1'b0;
    mismatches = 0;
    words_sent = 0;
    words_checked = 0;
    runs_done = 0;
    m_num_states = 5'd16;
    foreach (m_slot_ok[i]) begin
      m_slot_ok[i] = 1'b0;
      m_src[i] = '0;
      m_weight[i] = '0;
    end
    foreach (m_init_ok[i]) begin
      m_init_ok[i] = 1'b0;
      m_init[i] = '0;
    end
    foreach (m_bp[i]) m_bp[i] = '0;
    clear_decode();
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // A finish with no frames gives a single empty path word.
    none_word = '{6'd0, 4'd0, 1'b0, SCORE_MIN, 1'b0, 1'b0, 1'b1};
    rows.push_back('{mk(CMD_FINISH, 0, 0, 0, 0, 0), 1'b1, none_word});
    rows.push_back('{mk(CMD_LOAD_INIT, 0, 0, 0, 32'sh7fffffff, 1), 1'b0, '0});
    rows.push_back('{mk(CMD_LOAD_INIT, 1, 0, 0, 32'sh80000000, 1), 1'b0, '0});
    rows.push_back('{mk(CMD_LOAD_SLOT, 0, 0, 0, 32'sh7fffffff, 1), 1'b0, '0});
    rows.push_back('{mk(CMD_LOAD_SLOT, 0, 1, 1, 0, 1), 1'b0, '0});
    rows.push_back('{mk(CMD_LOAD_SLOT, 1, 0, 0, -65536, 1), 1'b0, '0});
    rows.push_back('{mk(CMD_LOAD_SLOT, 1, 1, 1, -65536, 1), 1'b0, '0});
    rows.push_back('{mk(CMD_LOAD_SLOT, 1, 15, 15, 32'sh7fffffff, 1), 1'b0, '0});
    rows.push_back('{mk(CMD_LOAD_SLOT, 0, 15, 3, 0, 0), 1'b0, '0});
    rows.push_back('{mk(CMD_EMISSION, 0, 15, 15, 32'sh7fffffff, 1), 1'b0, '0});
    rows.push_back('{mk(CMD_EMISSION, 0, 0, 0, 0, 1), 1'b0, '0});
    rows.push_back('{mk(CMD_EMISSION, 1, 0, 0, 32'sh80000000, 1), 1'b0, '0});
    rows.push_back('{mk(CMD_EMISSION, 0, 0, 0, 32'sh7fffffff, 1), 1'b0, '0});
    rows.push_back('{mk(CMD_EMISSION, 3, 0, 0, 0, 1), 1'b0, '0});
    rows.push_back('{mk(CMD_EMISSION, 1, 0, 0, 0, 0), 1'b0, '0});
    rows.push_back('{mk(CMD_EMISSION, 1, 0, 0, -1, 1), 1'b0, '0});
    rows.push_back('{mk(CMD_EMISSION, 0, 0, 0, 5, 1), 1'b0, '0});
    rows.push_back('{mk(CMD_FINISH, 0, 0, 0, 0, 0), 1'b0, '0});
    rows.push_back('{mk(CMD_FINISH, 15, 15, 15, -1, 1), 1'b1, none_word});
    rows.push_back('{mk(CMD_LOAD_INIT, 0, 0, 0, 0, 0), 1'b0, '0});
    rows.push_back('{mk(CMD_EMISSION, 0, 0, 0, 0, 1), 1'b0, '0});
    rows.push_back('{mk(CMD_EMISSION, 1, 0, 0, 0, 1), 1'b0, '0});
    rows.push_back('{mk(CMD_EMISSION, 1, 0, 0, 0, 1), 1'b0, '0});
    rows.push_back('{mk(CMD_FINISH, 0, 0, 0, 0, 0), 1'b0, '0});
    write_states(5'd2);
    foreach (rows[i]) send(rows[i].w, rows[i].typed, rows[i].exp_word);

    // Too many frames: a single-state run overruns the frame store, and the
    // receiver holds off while its traceback fills the block.
    write_states(5'd0);
    for (int f = 0; f < NUM_FRAMES + 2; f++)
      send(mk(CMD_EMISSION, 0, 0, 0, pick_score(), f != 7));
    hold_req = 1'b1;
    send(mk(CMD_FINISH, 0, 0, 0, 0, 0));
    for (int i = 0; i < 6; i++)
      send(mk(CMD_LOAD_INIT, i, 0, 0, pick_score(), 1'b1));

    write_states(5'd31);
    decode_run(1, 1'b0);

    while (words_sent < 180) begin
      write_states($urandom_range(0, 5) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 5));
      tx_fast = ($urandom_range(0, 3) == 0);
      rx_fast = ($urandom_range(0, 3) == 0);
      decode_run($urandom_range(1, 6), $urandom_range(0, 2) != 0);
    end
    tx_fast = 1'b0;
    rx_fast = 1'b0;
    settle();

    $display("Sent %0d input words over %0d decode runs; checked %0d path words.",
             words_sent, runs_done + 5, words_checked);
    $display("Mismatches: %0d.", mismatches);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: hmm_viterbi_decoder_unit.f
rtl/hvd_pkg.sv
rtl/hvd_ram.sv
rtl/hvd_ctrl.sv
rtl/hvd_datapath.sv
rtl/hmm_viterbi_decoder_unit.sv
tb/testbench.sv
